>>> rtl/nearest_scale_color_key_rgba_assert.svh
// Assertion macros for the nearest-neighbor scaler with color key.
// Included by the top level; needs nothing else.
`ifndef NEAREST_SCALE_COLOR_KEY_RGBA_ASSERT_SVH
`define NEAREST_SCALE_COLOR_KEY_RGBA_ASSERT_SVH

// Antecedent in one cycle implies the consequent in the same cycle.
`define NCSK_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ncsk assertion failed");

// Antecedent in one cycle implies the consequent sequence from the next cycle on.
`define NCSK_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> cons) \
      else $error("ncsk assertion failed");

`endif

>>> rtl/ncsk_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the nearest-neighbor scaler with color key.
// No dependencies.
package ncsk_pkg;

   // Request modes.
   localparam logic MODE_LOAD  = 1'b0;
   localparam logic MODE_FETCH = 1'b1;

   // Alpha values for keyed and opaque pixels.
   localparam logic [7:0] ALPHA_CLEAR  = 8'h00;
   localparam logic [7:0] ALPHA_OPAQUE = 8'hff;

   // Configuration register indexes (byte address divided by four).
   typedef enum logic [2:0] {
      REG_SRC_WIDTH  = 3'd0,
      REG_SRC_HEIGHT = 3'd1,
      REG_X_SCALE    = 3'd2,
      REG_Y_SCALE    = 3'd3,
      REG_KEY_ENABLE = 3'd4,
      REG_KEY_COLOR  = 3'd5
   } reg_index_type;

   localparam int unsigned CSR_ADDR_WIDTH = 5;
   localparam int unsigned CSR_DATA_WIDTH = 32;

   // Register reset values.
   localparam logic [8:0]  SRC_SIZE_RESET = 9'd256;
   localparam logic [23:0] SCALE_RESET    = 24'h010000;

   // Configuration as seen by the datapath.
   typedef struct packed {
      logic [8:0]  src_width;
      logic [8:0]  src_height;
      logic [23:0] x_scale;
      logic [23:0] y_scale;
      logic        key_enable;
      logic [23:0] key_color;
   } cfg_type;

endpackage

>>> rtl/nearest_scale_color_key_rgba.sv
`timescale 1ns / 1ps
// Nearest-neighbor scaler with color key. An accepted fetch request passes the input,
// product, RAM read and result registers and shows on the rsp ports, strobed for one cycle.
// Throughput: one request per cycle, loads and fetches mixed; busy is never high and the
// receiver cannot stall. Rate is set by the registered multiply and one RAM port pair.
// Reset clears the pipeline and the registers; the frame store is not cleared.
// Depends on ncsk_pkg, ncsk_csr, ncsk_scale, ncsk_ram and the assertion header.
`include "nearest_scale_color_key_rgba_assert.svh"

module nearest_scale_color_key_rgba #(
   parameter int unsigned MAX_SIDE = 256
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic                                 req_mode,
   input  logic [7:0]                           req_coord_x,
   input  logic [7:0]                           req_coord_y,
   input  logic [23:0]                          req_pixel_in,
   output logic                                 rsp_strobe,
   output logic [23:0]                          rsp_pixel_out,
   output logic [7:0]                           rsp_alpha,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [ncsk_pkg::CSR_ADDR_WIDTH-1:0]  paddr,
   input  logic [ncsk_pkg::CSR_DATA_WIDTH-1:0]  pwdata,
   output logic [ncsk_pkg::CSR_DATA_WIDTH-1:0]  prdata,
   output logic                                 pready
);

   localparam int unsigned SideWidth = $clog2(MAX_SIDE);
   localparam int unsigned AddrWidth = 2 * SideWidth;
   localparam int unsigned Depth     = 1 << AddrWidth;
   localparam logic [12:0] SideLimit = 13'(MAX_SIDE);

   ncsk_pkg::cfg_type      cfg;

   // Input register.
   logic                   s0_valid_ff;
   logic                   s0_mode_ff;
   logic [7:0]             s0_x_ff;
   logic [7:0]             s0_y_ff;
   logic [23:0]            s0_pixel_ff;

   // Fetch markers down the pipeline.
   logic                   s1_fetch_ff;
   logic                   s2_fetch_ff;

   // Result register.
   logic                   rsp_strobe_ff;
   logic [23:0]            rsp_pixel_ff;
   logic [7:0]             rsp_alpha_ff;
   logic [7:0]             rsp_alpha_in;

   logic                   accept;
   logic                   take_fetch;
   logic                   take_load;
   logic                   s0_load;
   logic                   in_store;
   logic                   wr_en;
   logic [AddrWidth-1:0]   wr_addr;
   logic [SideWidth-1:0]   idx_x;
   logic [SideWidth-1:0]   idx_y;
   logic [23:0]            rd_data;

   assign busy       = 1'b0;
   assign accept     = start && !busy;
   assign take_fetch = accept && (req_mode == ncsk_pkg::MODE_FETCH);
   assign take_load  = accept && (req_mode == ncsk_pkg::MODE_LOAD);

   ncsk_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // Capture every accepted request.
   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else begin
         s0_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      s0_mode_ff  <= req_mode;
      s0_x_ff     <= req_coord_x;
      s0_y_ff     <= req_coord_y;
      s0_pixel_ff <= req_pixel_in;
   end

   // Loads write straight from the input register; off-store coordinates are dropped.
   assign s0_load  = s0_valid_ff && (s0_mode_ff == ncsk_pkg::MODE_LOAD);
   assign in_store = ({5'd0, s0_x_ff} < SideLimit) && ({5'd0, s0_y_ff} < SideLimit);
   assign wr_en    = s0_load && in_store;
   assign wr_addr  = {SideWidth'(s0_y_ff), SideWidth'(s0_x_ff)};

   // Coordinate mapping, one unit per axis.
   ncsk_scale #(
      .MAX_SIDE    (MAX_SIDE),
      .INDEX_WIDTH (SideWidth)
   ) u_scale_x (
      .clock (clock),
      .coord (s0_x_ff),
      .scale (cfg.x_scale),
      .size  (cfg.src_width),
      .index (idx_x)
   );

   ncsk_scale #(
      .MAX_SIDE    (MAX_SIDE),
      .INDEX_WIDTH (SideWidth)
   ) u_scale_y (
      .clock (clock),
      .coord (s0_y_ff),
      .scale (cfg.y_scale),
      .size  (cfg.src_height),
      .index (idx_y)
   );

   // Frame store.
   ncsk_ram #(
      .WIDTH (24),
      .DEPTH (Depth)
   ) u_frame_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (s0_pixel_ff),
      .rd_addr ({idx_y, idx_x}),
      .rd_data (rd_data)
   );

   // Track fetches alongside the multiply and RAM read stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_fetch_ff   <= 1'b0;
         s2_fetch_ff   <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         s1_fetch_ff   <= s0_valid_ff && (s0_mode_ff == ncsk_pkg::MODE_FETCH);
         s2_fetch_ff   <= s1_fetch_ff;
         rsp_strobe_ff <= s2_fetch_ff;
      end
   end

   // Color key test and result register.
   assign rsp_alpha_in = (cfg.key_enable && (rd_data == cfg.key_color)) ?
                         ncsk_pkg::ALPHA_CLEAR : ncsk_pkg::ALPHA_OPAQUE;

   always_ff @(posedge clock) begin
      rsp_pixel_ff <= rd_data;
      rsp_alpha_ff <= rsp_alpha_in;
   end

   assign rsp_strobe    = rsp_strobe_ff;
   assign rsp_pixel_out = rsp_pixel_ff;
   assign rsp_alpha     = rsp_alpha_ff;

   // Every fetch strobes exactly one result on the ports; loads give none.
   `NCSK_ASSERT_NEXT(a_fetch_result, clock, reset, take_fetch, ##3 rsp_strobe)
   `NCSK_ASSERT_NEXT(a_load_silent, clock, reset, take_load, ##3 !rsp_strobe)
   // A load in the input register never enters the fetch pipeline.
   `NCSK_ASSERT_NEXT(a_load_not_fetch, clock, reset, s0_load, !s1_fetch_ff)

endmodule

>>> rtl/ncsk_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one registered read port.
// A read at the address being written returns the old data. No dependencies.
module ncsk_ram #(
   parameter int unsigned WIDTH = 24,
   parameter int unsigned DEPTH = 65536
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/ncsk_csr.sv
`timescale 1ns / 1ps
// APB-style configuration registers of the scaler.
// Depends on ncsk_pkg.
module ncsk_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [ncsk_pkg::CSR_ADDR_WIDTH-1:0]  paddr,
   input  logic [ncsk_pkg::CSR_DATA_WIDTH-1:0]  pwdata,
   output logic [ncsk_pkg::CSR_DATA_WIDTH-1:0]  prdata,
   output logic                                 pready,
   output ncsk_pkg::cfg_type                    cfg
);

   ncsk_pkg::cfg_type cfg_ff;
   ncsk_pkg::cfg_type cfg_in;
   logic              wr_hit;
   logic [2:0]        reg_sel;

   assign pready  = 1'b1;
   assign wr_hit  = psel && penable && pwrite;
   assign reg_sel = paddr[4:2];

   // Register write decode; indexes past the list are ignored.
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_hit) begin
         unique case (reg_sel)
            ncsk_pkg::REG_SRC_WIDTH:  cfg_in.src_width  = pwdata[8:0];
            ncsk_pkg::REG_SRC_HEIGHT: cfg_in.src_height = pwdata[8:0];
            ncsk_pkg::REG_X_SCALE:    cfg_in.x_scale    = pwdata[23:0];
            ncsk_pkg::REG_Y_SCALE:    cfg_in.y_scale    = pwdata[23:0];
            ncsk_pkg::REG_KEY_ENABLE: cfg_in.key_enable = pwdata[0];
            ncsk_pkg::REG_KEY_COLOR:  cfg_in.key_color  = pwdata[23:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.src_width  <= ncsk_pkg::SRC_SIZE_RESET;
         cfg_ff.src_height <= ncsk_pkg::SRC_SIZE_RESET;
         cfg_ff.x_scale    <= ncsk_pkg::SCALE_RESET;
         cfg_ff.y_scale    <= ncsk_pkg::SCALE_RESET;
         cfg_ff.key_enable <= 1'b0;
         cfg_ff.key_color  <= 24'd0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read mux, zero-extended to the bus width.
   always_comb begin
      unique case (reg_sel)
         ncsk_pkg::REG_SRC_WIDTH:  prdata = {23'd0, cfg_ff.src_width};
         ncsk_pkg::REG_SRC_HEIGHT: prdata = {23'd0, cfg_ff.src_height};
         ncsk_pkg::REG_X_SCALE:    prdata = {8'd0, cfg_ff.x_scale};
         ncsk_pkg::REG_Y_SCALE:    prdata = {8'd0, cfg_ff.y_scale};
         ncsk_pkg::REG_KEY_ENABLE: prdata = {31'd0, cfg_ff.key_enable};
         ncsk_pkg::REG_KEY_COLOR:  prdata = {8'd0, cfg_ff.key_color};
         default:                  prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

>>> rtl/ncsk_scale.sv
`timescale 1ns / 1ps
// One axis of the coordinate mapper: registered coord * scale in Q8.16,
// then the integer part clamped to the effective source size minus one. No dependencies.
module ncsk_scale #(
   parameter int unsigned MAX_SIDE    = 256,
   parameter int unsigned INDEX_WIDTH = 8
) (
   input  logic                   clock,
   input  logic [7:0]             coord,
   input  logic [23:0]            scale,
   input  logic [8:0]             size,
   output logic [INDEX_WIDTH-1:0] index
);

   localparam logic [15:0] MaxLast = 16'(MAX_SIDE - 1);

   logic [31:0] product_ff;
   logic [31:0] product_in;
   logic [15:0] size_m1;
   logic [15:0] last;
   logic [15:0] pos;
   logic [15:0] clamped;

   // Exact product; the integer part sits in the upper 16 bits.
   assign product_in = {24'd0, coord} * {8'd0, scale};

   always_ff @(posedge clock) begin
      product_ff <= product_in;
   end

   // Effective size minus one: zero size acts as one, oversize saturates.
   assign size_m1 = (size == 9'd0) ? 16'd0 : ({7'd0, size} - 16'd1);
   assign last    = (size_m1 > MaxLast) ? MaxLast : size_m1;

   // Clamp the source position to the last row or column.
   assign pos     = product_ff[31:16];
   assign clamped = (pos > last) ? last : pos;
   assign index   = clamped[INDEX_WIDTH-1:0];

endmodule

>>> bench/nearest_scale_color_key_rgba_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for nearest_scale_color_key_rgba: loads source pixels, fetches
// scaled pixels under several register settings and checks every response against a predictor.
// Depends on ncsk_pkg and the block's RTL.
module nearest_scale_color_key_rgba_tb;

   localparam int CLOCK_PERIOD = 12;
   localparam int RESET_CYCLES = 6;
   localparam int DRAIN_CYCLES = 8;
   localparam int STALL_LIMIT  = 2000;
   localparam int MAX_REPORTS  = 10;
   localparam int PHASE_ITEMS  = 70;
   localparam int RANDOM_PHASES = 8;

   // Register indexes past the end of the map; writes there must be ignored.
   localparam logic [2:0] SPARE_INDEX_LO = 3'd6;
   localparam logic [2:0] SPARE_INDEX_HI = 3'd7;

   typedef struct packed {
      logic        mode;
      logic [7:0]  coord_x;
      logic [7:0]  coord_y;
      logic [23:0] pixel;
   } pixel_request_type;

   typedef struct packed {
      logic [23:0] pixel;
      logic [7:0]  alpha;
   } keyed_pixel_type;

   logic                                 clock;
   logic                                 reset = 1'b1;
   logic                                 start = 1'b0;
   logic                                 busy;
   logic                                 req_mode = ncsk_pkg::MODE_LOAD;
   logic [7:0]                           req_coord_x = 8'd0;
   logic [7:0]                           req_coord_y = 8'd0;
   logic [23:0]                          req_pixel_in = 24'd0;
   logic                                 rsp_strobe;
   logic [23:0]                          rsp_pixel_out;
   logic [7:0]                           rsp_alpha;
   logic                                 psel = 1'b0;
   logic                                 penable = 1'b0;
   logic                                 pwrite = 1'b0;
   logic [ncsk_pkg::CSR_ADDR_WIDTH-1:0]  paddr = '0;
   logic [ncsk_pkg::CSR_DATA_WIDTH-1:0]  pwdata = '0;
   logic [ncsk_pkg::CSR_DATA_WIDTH-1:0]  prdata;
   logic                                 pready;

   // Predictor state: a copy of the frame store and of the registers.
   logic [23:0]         frame_copy [0:65535];
   bit                  loaded_map [0:65535];
   ncsk_pkg::cfg_type   shadow_cfg;

   pixel_request_type request_queue [$];
   keyed_pixel_type   expected_pixels [$];

   pixel_request_type current;
   bit             holding = 1'b0;
   int             idle_left = 0;
   int             calm_left = 0;
   int             req_count = 0;
   int             rsp_count = 0;
   int             csr_count = 0;
   int             error_count = 0;
   int             stall_cycles = 0;
   int             seen_total = 0;

   nearest_scale_color_key_rgba u_dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_mode      (req_mode),
      .req_coord_x   (req_coord_x),
      .req_coord_y   (req_coord_y),
      .req_pixel_in  (req_pixel_in),
      .rsp_strobe    (rsp_strobe),
      .rsp_pixel_out (rsp_pixel_out),
      .rsp_alpha     (rsp_alpha),
      .psel          (psel),
      .penable       (penable),
      .pwrite        (pwrite),
      .paddr         (paddr),
      .pwdata        (pwdata),
      .prdata        (prdata),
      .pready        (pready)
   );

   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   // Size register as the datapath uses it: zero means one, anything past 256 means 256.
   function automatic int clamp_side(logic [8:0] side);
      if (side == 9'd0) return 1;
      if (side > 9'd256) return 256;
      return int'(side);
   endfunction

   // Output coordinate to source coordinate: floor(coord * scale) in Q8.16, clamped.
   function automatic logic [7:0] map_coord(logic [7:0] coord, logic [23:0] scale, int side);
      logic [31:0] product;
      logic [15:0] whole;
      product = {24'd0, coord} * {8'd0, scale};
      whole = product[31:16];
      if (int'(whole) > side - 1) return 8'(side - 1);
      return whole[7:0];
   endfunction

   function automatic logic [15:0] fetch_address(logic [7:0] x, logic [7:0] y);
      return {map_coord(y, shadow_cfg.y_scale, clamp_side(shadow_cfg.src_height)),
              map_coord(x, shadow_cfg.x_scale, clamp_side(shadow_cfg.src_width))};
   endfunction

   // Applies one accepted request to the frame copy and queues the pixel a fetch returns.
   function automatic void predict_request(pixel_request_type r);
      logic [15:0]     addr;
      keyed_pixel_type result;
      if (r.mode == ncsk_pkg::MODE_LOAD) begin
         frame_copy[{r.coord_y, r.coord_x}] = r.pixel;
      end else begin
         addr = fetch_address(r.coord_x, r.coord_y);
         result.pixel = frame_copy[addr];
         result.alpha = (shadow_cfg.key_enable && result.pixel == shadow_cfg.key_color) ?
                        ncsk_pkg::ALPHA_CLEAR : ncsk_pkg::ALPHA_OPAQUE;
         expected_pixels.push_back(result);
      end
   endfunction

   // Value a register read returns under the shadow settings; unmapped indexes read zero.
   function automatic logic [31:0] csr_readback(logic [2:0] index);
      logic [31:0] value;
      value = '0;
      unique case (index)
         ncsk_pkg::REG_SRC_WIDTH:  value = {23'd0, shadow_cfg.src_width};
         ncsk_pkg::REG_SRC_HEIGHT: value = {23'd0, shadow_cfg.src_height};
         ncsk_pkg::REG_X_SCALE:    value = {8'd0, shadow_cfg.x_scale};
         ncsk_pkg::REG_Y_SCALE:    value = {8'd0, shadow_cfg.y_scale};
         ncsk_pkg::REG_KEY_ENABLE: value = {31'd0, shadow_cfg.key_enable};
         ncsk_pkg::REG_KEY_COLOR:  value = {8'd0, shadow_cfg.key_color};
         default: ;
      endcase
      return value;
   endfunction

   function automatic logic [23:0] draw_pixel();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 15) return shadow_cfg.key_color;
      if (pick < 22) return 24'h000000;
      if (pick < 29) return 24'hffffff;
      return 24'($urandom_range(0, 24'hffffff));
   endfunction

   function automatic logic [7:0] draw_coord();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 15) return 8'd0;
      if (pick < 30) return 8'd255;
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic logic [8:0] draw_side();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 12) return 9'd0;
      if (pick < 30) return 9'd256;
      if (pick < 42) return 9'($urandom_range(257, 511));
      if (pick < 60) return 9'($urandom_range(1, 8));
      return 9'($urandom_range(1, 256));
   endfunction

   function automatic logic [23:0] draw_scale();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 10) return 24'h000000;
      if (pick < 20) return 24'hffffff;
      if (pick < 40) return ncsk_pkg::SCALE_RESET;
      if (pick < 75) return 24'($urandom_range(24'h002000, 24'h020000));
      return 24'($urandom_range(0, 24'hffffff));
   endfunction

   function automatic void queue_load(logic [7:0] x, logic [7:0] y, logic [23:0] pixel);
      pixel_request_type r;
      r.mode = ncsk_pkg::MODE_LOAD;
      r.coord_x = x;
      r.coord_y = y;
      r.pixel = pixel;
      request_queue.push_back(r);
      loaded_map[{y, x}] = 1'b1;
   endfunction

   // A fetch whose source pixel was never loaded gets a load of that pixel in front of it.
   function automatic void queue_fetch(logic [7:0] x, logic [7:0] y);
      pixel_request_type r;
      logic [15:0]       addr;
      addr = fetch_address(x, y);
      if (!loaded_map[addr]) queue_load(addr[7:0], addr[15:8], draw_pixel());
      r.mode = ncsk_pkg::MODE_FETCH;
      r.coord_x = x;
      r.coord_y = y;
      r.pixel = 24'($urandom_range(0, 24'hffffff));
      request_queue.push_back(r);
   endfunction

   function automatic void queue_random(int count);
      repeat (count) begin
         if ($urandom_range(0, 99) < 35)
            queue_load(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), draw_pixel());
         else
            queue_fetch(draw_coord(), draw_coord());
      end
   endfunction

   // Gap after a request: mostly none, sometimes short, rarely a long pause; now and then a run with no gaps.
   function automatic int next_gap();
      int pick;
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      pick = $urandom_range(0, 99);
      if (pick < 3) calm_left = $urandom_range(20, 60);
      if (pick < 60) return 0;
      if (pick < 85) return $urandom_range(1, 3);
      if (pick < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Fills the bits above a register's width with noise.
   function automatic logic [31:0] pad_junk(logic [31:0] value, int width);
      return ($urandom << width) | value;
   endfunction

   function automatic void report_mismatch(string what, logic [31:0] want, logic [31:0] got);
      error_count++;
      if (error_count <= MAX_REPORTS)
         $display("%0t: %s: expected %h, got %h", $time, what, want, got);
   endfunction

   // One APB write: setup cycle, then access cycle until pready; then the value reads back.
   task automatic csr_write(input logic [2:0] index, input logic [31:0] data);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {index, 2'b00};
      pwdata <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      csr_count++;
      unique case (index)
         ncsk_pkg::REG_SRC_WIDTH:  shadow_cfg.src_width = data[8:0];
         ncsk_pkg::REG_SRC_HEIGHT: shadow_cfg.src_height = data[8:0];
         ncsk_pkg::REG_X_SCALE:    shadow_cfg.x_scale = data[23:0];
         ncsk_pkg::REG_Y_SCALE:    shadow_cfg.y_scale = data[23:0];
         ncsk_pkg::REG_KEY_ENABLE: shadow_cfg.key_enable = data[0];
         ncsk_pkg::REG_KEY_COLOR:  shadow_cfg.key_color = data[23:0];
         default: ;
      endcase
      // The address stays on the bus, so the read data shows the new register value.
      @(negedge clock);
      if (prdata !== csr_readback(index))
         report_mismatch("register readback", csr_readback(index), prdata);
   endtask

   // Writes every register, then both unmapped indexes to show they alias nothing.
   task automatic program_config(input logic [8:0] width, input logic [8:0] height,
                                 input logic [23:0] xs, input logic [23:0] ys,
                                 input logic key_on, input logic [23:0] key);
      csr_write(ncsk_pkg::REG_SRC_WIDTH, pad_junk({23'd0, width}, 9));
      csr_write(ncsk_pkg::REG_SRC_HEIGHT, pad_junk({23'd0, height}, 9));
      csr_write(ncsk_pkg::REG_X_SCALE, pad_junk({8'd0, xs}, 24));
      csr_write(ncsk_pkg::REG_Y_SCALE, pad_junk({8'd0, ys}, 24));
      csr_write(ncsk_pkg::REG_KEY_ENABLE, pad_junk({31'd0, key_on}, 1));
      csr_write(ncsk_pkg::REG_KEY_COLOR, pad_junk({8'd0, key}, 24));
      csr_write(SPARE_INDEX_LO, $urandom);
      csr_write(SPARE_INDEX_HI, $urandom);
   endtask

   // Waits until every request is taken and every response is in, then lets a trailing
   // load finish inside the pipeline.
   task automatic wait_idle();
      while (request_queue.size() != 0 || holding || expected_pixels.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Request driver: presents queued requests with random gaps between them.
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
         holding = 1'b0;
         idle_left = 0;
      end else begin
         if (holding && !busy) begin
            predict_request(current);
            req_count++;
            holding = 1'b0;
         end
         if (!holding) begin
            if (idle_left > 0 || request_queue.size() == 0) begin
               if (idle_left > 0) idle_left--;
               start <= 1'b0;
            end else begin
               current = request_queue.pop_front();
               req_mode <= current.mode;
               req_coord_x <= current.coord_x;
               req_coord_y <= current.coord_y;
               req_pixel_in <= current.pixel;
               start <= 1'b1;
               holding = 1'b1;
               idle_left = next_gap();
            end
         end
      end
   end

   // Response monitor: every strobe must match the oldest outstanding fetch.
   always @(posedge clock) begin
      if (!reset && rsp_strobe !== 1'b0) begin
         rsp_count++;
         if (expected_pixels.size() == 0) begin
            report_mismatch("response with no fetch outstanding", 32'd0,
                            {rsp_pixel_out, rsp_alpha});
         end else begin
            if (rsp_pixel_out !== expected_pixels[0].pixel)
               report_mismatch("pixel_out", {8'd0, expected_pixels[0].pixel},
                               {8'd0, rsp_pixel_out});
            if (rsp_alpha !== expected_pixels[0].alpha)
               report_mismatch("alpha", {24'd0, expected_pixels[0].alpha},
                               {24'd0, rsp_alpha});
            void'(expected_pixels.pop_front());
         end
      end
   end

   // Watchdog: ends the run after too many cycles without any handshake.
   always @(posedge clock) begin
      if (reset || req_count + rsp_count + csr_count != seen_total) begin
         seen_total = req_count + rsp_count + csr_count;
         stall_cycles = 0;
      end else begin
         stall_cycles++;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
         end
      end
   end

   initial begin
      shadow_cfg.src_width = ncsk_pkg::SRC_SIZE_RESET;
      shadow_cfg.src_height = ncsk_pkg::SRC_SIZE_RESET;
      shadow_cfg.x_scale = ncsk_pkg::SCALE_RESET;
      shadow_cfg.y_scale = ncsk_pkg::SCALE_RESET;
      shadow_cfg.key_enable = 1'b0;
      shadow_cfg.key_color = 24'h000000;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Corners and an interior pixel under the reset settings, keying off, then a
      // fetch directly behind a load that overwrites the same pixel.
      queue_load(8'd0, 8'd0, 24'h000000);
      queue_load(8'd255, 8'd255, 24'hffffff);
      queue_load(8'd255, 8'd0, 24'hff0000);
      queue_load(8'd0, 8'd255, 24'h0000ff);
      queue_load(8'd128, 8'd64, 24'h00ff00);
      queue_fetch(8'd0, 8'd0);
      queue_fetch(8'd255, 8'd255);
      queue_fetch(8'd255, 8'd0);
      queue_fetch(8'd0, 8'd255);
      queue_fetch(8'd128, 8'd64);
      queue_load(8'd128, 8'd64, 24'h123456);
      queue_fetch(8'd128, 8'd64);
      wait_idle();

      // Width past the store, height zero, largest x scale overflowing into the clamp,
      // zero y scale, keying on red.
      program_config(9'd511, 9'd0, 24'hffffff, 24'h000000, 1'b1, 24'hff0000);
      queue_fetch(8'd255, 8'd255);
      queue_fetch(8'd0, 8'd0);
      queue_fetch(8'd1, 8'd200);
      wait_idle();

      // Zero width, full-store height, zero x scale, largest y scale, keying on black.
      program_config(9'd0, 9'd256, 24'h000000, 24'hffffff, 1'b1, 24'h000000);
      queue_fetch(8'd200, 8'd255);
      queue_fetch(8'd0, 8'd0);
      queue_fetch(8'd255, 8'd1);

      // Random settings, each followed by a stream of loads and fetches.
      repeat (RANDOM_PHASES) begin
         wait_idle();
         program_config(draw_side(), draw_side(), draw_scale(), draw_scale(),
                        1'($urandom_range(0, 1)),
                        ($urandom_range(0, 3) == 0) ? 24'hffffff :
                                                      24'($urandom_range(0, 24'hffffff)));
         queue_random(PHASE_ITEMS);
      end
      wait_idle();

      if (error_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
